>>> rtl/core/lkt_pkg.sv
package lkt_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int KEY_BITS        = 32;
   localparam int COUNT_W         = 5;
   localparam int CAP_W           = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_USE    = 2'd2,
      FUNC_FIND   = 2'd3
   } func_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_APPLY = 1'b1
   } state_type;

   typedef struct packed {
      func_type              func;
      logic [KEY_BITS-1:0]   key;
   } req_type;

   typedef struct packed {
      logic                  flag;
      logic [COUNT_W-1:0]    count;
   } rsp_type;

   // Broadcast from the sequencer to every cell of the row.
   typedef struct packed {
      logic                  capture;
      logic                  apply;
      func_type              func;
      logic                  hit;
      logic [KEY_BITS-1:0]   key;
   } cell_ctl_type;

endpackage

>>> rtl/core/lkt_cell.sv
module lkt_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  logic                        clock,
   input  lkt_pkg::cell_ctl_type       ctl,
   input  logic [CNT_W-1:0]            count,
   input  logic [lkt_pkg::KEY_BITS-1:0] left_key,
   input  logic [lkt_pkg::KEY_BITS-1:0] right_key,
   input  logic                        upto_self,
   input  logic                        upto_left,
   output logic [lkt_pkg::KEY_BITS-1:0] key_out,
   output logic                        match_out
);
   import lkt_pkg::*;

   localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                match_ff, match_in;

   // Match only counts for entries that are inside the live part of the list.
   assign match_in = (key_ff == ctl.key) && (IDX_C < count);

   always_comb begin
      key_in = key_ff;
      if (ctl.apply) begin
         case (ctl.func)
            FUNC_INSERT: begin
               key_in = (IDX == 0) ? ctl.key : left_key;
            end
            FUNC_REMOVE: begin
               // close the gap: everything from the first match on moves forward
               if (ctl.hit && upto_self) key_in = right_key;
            end
            FUNC_USE: begin
               if (ctl.hit) begin
                  if (IDX == 0)        key_in = ctl.key;
                  else if (!upto_left) key_in = left_key;
               end
            end
            default: key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (ctl.capture) match_ff <= match_in;
   end

   assign key_out   = key_ff;
   assign match_out = match_ff;

endmodule

>>> rtl/core/lru_key_table_top.sv
// Channel  | Ports                          | Payload
// ---------+--------------------------------+---------------------------------
// request  | req_valid, req_ready, req_data | lkt_pkg::req_type  (func, key)
// response | rsp_valid, rsp_ready, rsp_data | lkt_pkg::rsp_type  (flag, count)
// csr      | csr_valid, csr_ready, csr_data | capacity, 5 bits
//
// In the transfer cycle every cell compares the key with its entry; in the
// apply state that follows, the row shifts and the response is loaded into
// the output register. Cost is set by that one compare/shift pass across the
// row of cells. A stalled response holds the row in the apply state until
// the output register frees. Reset clears the count, the capacity (to 16)
// and the handshake state; cell contents stay undefined.
module lru_key_table_top #(
   parameter int MAX_ENTRIES = lkt_pkg::MAX_ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  lkt_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lkt_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lkt_pkg::CAP_W-1:0]  csr_data
);
   import lkt_pkg::*;

   localparam int N     = MAX_ENTRIES;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CAP_W-1:0]     capacity_ff;
   func_type             func_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   cell_ctl_type         ctl;
   logic [KEY_BITS-1:0]  cell_key [N];
   logic [N-1:0]         match;
   logic [N-1:0]         first;
   logic [N-1:0]         upto;
   logic                 hit;
   logic                 accept;
   logic                 commit;
   logic                 flag;
   logic [CNT_W-1:0]     eff_cap;
   logic [CNT_W-1:0]     less_one;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);

   // Clamp capacity: zero acts as one, anything above the row acts as the row.
   always_comb begin
      if (capacity_ff == '0)
         eff_cap = CNT_W'(1);
      else if (32'(capacity_ff) > 32'(MAX_ENTRIES))
         eff_cap = CNT_W'(MAX_ENTRIES);
      else
         eff_cap = CNT_W'(capacity_ff);
   end

   // Isolate the frontmost match, then mark every cell at or behind it.
   assign hit   = |match;
   assign first = match & (~match + N'(1));
   assign upto  = ~(first - N'(1));

   always_comb begin
      ctl.capture = accept;
      ctl.apply   = commit;
      ctl.func    = accept ? req_data.func : func_ff;
      ctl.hit     = hit;
      ctl.key     = accept ? req_data.key : key_ff;
   end

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         logic [KEY_BITS-1:0] left_key;
         logic [KEY_BITS-1:0] right_key;
         logic                upto_left;

         if (g == 0) begin : g_front
            assign left_key  = cell_key[0];
            assign upto_left = 1'b0;
         end else begin : g_mid
            assign left_key  = cell_key[g-1];
            assign upto_left = upto[g-1];
         end
         if (g == N - 1) begin : g_rear
            assign right_key = cell_key[g];
         end else begin : g_inner
            assign right_key = cell_key[g+1];
         end

         lkt_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .count     (count_ff),
            .left_key  (left_key),
            .right_key (right_key),
            .upto_self (upto[g]),
            .upto_left (upto_left),
            .key_out   (cell_key[g]),
            .match_out (match[g])
         );
      end
   endgenerate

   // Next count and flag for the item in the apply cycle.
   assign less_one = count_ff - CNT_W'(1);

   always_comb begin
      count_in = count_ff;
      flag     = 1'b0;
      case (func_ff)
         FUNC_INSERT: begin
            flag     = (count_ff >= eff_cap);
            count_in = flag ? count_ff : count_ff + CNT_W'(1);
         end
         FUNC_REMOVE: begin
            flag = hit;
            if (hit) count_in = less_one;
         end
         FUNC_USE: begin
            // after the removal an over-full list drops its rear entry again
            flag = hit;
            if (hit && (less_one >= eff_cap)) count_in = less_one;
         end
         default: begin
            flag = hit;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_APPLY;
         ST_APPLY: if (commit) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) count_ff <= count_in;
         if (csr_valid && csr_ready) capacity_ff <= csr_data;
         // advance the output register: load on commit, drop on transfer
         if (commit)         rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_data.func;
         key_ff  <= req_data.key;
      end
      if (commit) begin
         rsp_data_ff.flag  <= flag;
         rsp_data_ff.count <= COUNT_W'(count_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/core/lkt_checker.sv
module lkt_checker #(
   parameter int MAX_ENTRIES = lkt_pkg::MAX_ENTRIES_DEF
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input lkt_pkg::rsp_type          rsp_data
);
   import lkt_pkg::*;

   // A held response keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // One item at a time: no new request right after a transfer.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous item in flight");

   // The count never exceeds the row of cells.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_data.count) <= 32'(MAX_ENTRIES))
      else $error("count above table size");

   // No response right out of reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind lru_key_table_top lkt_checker #(
   .MAX_ENTRIES (MAX_ENTRIES)
) u_lkt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> bench/lru_key_table_tb.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lkt_pkg::*;

   localparam int ROW_DEPTH = MAX_ENTRIES_DEF;

   // Mirror of the table: tracks key order, entry count and capacity, and
   // holds the responses the block still owes, oldest first.
   class lru_table_checker;
      logic [KEY_BITS-1:0] keys [ROW_DEPTH];
      int unsigned         held;
      logic [CAP_W-1:0]    capacity;
      rsp_type             owed_rsp [$];
      int                  errors;
      int                  requests;
      int                  flagged;

      function new();
         held     = 0;
         capacity = CAP_RESET;
         errors   = 0;
         requests = 0;
         flagged  = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] value);
         capacity = value;
      endfunction

      function int pending();
         return owed_rsp.size();
      endfunction

      // Zero acts as one; anything past the row depth acts as the depth.
      function int unsigned room();
         int unsigned c;
         c = capacity;
         if (c == 0) c = 1;
         if (c > ROW_DEPTH) c = ROW_DEPTH;
         return c;
      endfunction

      function bit push_front(logic [KEY_BITS-1:0] k);
         bit          evict;
         int unsigned n;
         evict = (held >= room());
         n = evict ? held - 1 : held;
         if (n > ROW_DEPTH - 1) n = ROW_DEPTH - 1;
         for (int i = n; i > 0; i--) keys[i] = keys[i-1];
         keys[0] = k;
         held = n + 1;
         return evict;
      endfunction

      // Frontmost match, or held when the key is absent.
      function int unsigned locate(logic [KEY_BITS-1:0] k);
         for (int unsigned i = 0; i < held; i++)
            if (keys[i] == k) return i;
         return held;
      endfunction

      function bit take_out(logic [KEY_BITS-1:0] k);
         int unsigned pos;
         pos = locate(k);
         if (pos >= held) return 1'b0;
         for (int unsigned i = pos; i + 1 < held; i++) keys[i] = keys[i+1];
         held--;
         return 1'b1;
      endfunction

      function void note_request(req_type r);
         rsp_type want;
         want.flag = 1'b0;
         case (r.func)
            FUNC_INSERT: want.flag = push_front(r.key);
            FUNC_REMOVE: want.flag = take_out(r.key);
            FUNC_USE: begin
               if (take_out(r.key)) begin
                  void'(push_front(r.key));
                  want.flag = 1'b1;
               end
            end
            default: want.flag = (locate(r.key) < held);
         endcase
         want.count = COUNT_W'(held);
         owed_rsp.push_back(want);
         requests++;
         if (want.flag) flagged++;
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (owed_rsp.size() == 0) begin
            $display("%0t: unexpected response flag=%0b count=%0d",
                     $time, got.flag, got.count);
            errors++;
            return;
         end
         want = owed_rsp.pop_front();
         if (got.flag !== want.flag) begin
            $display("%0t: flag mismatch, expected %0b, got %0b",
                     $time, want.flag, got.flag);
            errors++;
         end
         if (got.count !== want.count) begin
            $display("%0t: count mismatch, expected %0d, got %0d",
                     $time, want.count, got.count);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data;

   int                  send_idle_pct;
   int                  rsp_stall_pct;
   int                  cap_writes;
   logic [KEY_BITS-1:0] key_pool [8];
   lru_table_checker    table_chk;

   lru_key_table_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Hard stop in case a handshake never completes.
   initial begin
      #5_000_000;
      $display("%0t: timeout, %0d responses still owed", $time, table_chk.pending());
      $display("DONE: errors detected");
      $finish;
   end

   // Receiver: pick ready at each falling edge from the current stall rate.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Check every response transfer against the oldest owed response.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) table_chk.check_response(rsp_data);
   end

   // Send one request. Entered and left at a falling edge; valid drops once
   // the transfer is done, and the next call may raise it again at once.
   task automatic issue(input func_type f, input logic [KEY_BITS-1:0] k);
      req_type r;
      r.func = f;
      r.key  = k;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data  = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      table_chk.note_request(r);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Drop valid and hold until every owed response has come back, then let
   // the row go quiet.
   task automatic settle();
      req_valid = 1'b0;
      while (table_chk.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // Capacity is only written while the table is idle.
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      settle();
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      table_chk.set_capacity(value);
      cap_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Mostly keys from a small pool so that lookups hit; now and then a fresh
   // random key so every key bit moves.
   function automatic logic [KEY_BITS-1:0] pick_key();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return key_pool[$urandom_range(0, 7)];
   endfunction

   // Lean toward inserts so the table fills up and evicts.
   function automatic func_type pick_func();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 35) return FUNC_INSERT;
      if (sel < 55) return FUNC_REMOVE;
      if (sel < 78) return FUNC_USE;
      return FUNC_FIND;
   endfunction

   initial begin
      logic [CAP_W-1:0] phase_cap [8];
      int               mode;

      table_chk  = new();
      cap_writes = 0;
      phase_cap  = '{5'd16, 5'd5, 5'd1, 5'd31, 5'd0, 5'd12, 5'd3, 5'd16};

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Lookups on an empty table all miss.
      issue(FUNC_FIND,   32'h0000_0000);
      issue(FUNC_REMOVE, 32'h0000_0000);
      issue(FUNC_USE,    32'h0000_0000);

      // Key extremes, with a duplicate of the all-ones key.
      issue(FUNC_INSERT, 32'h0000_0000);
      issue(FUNC_INSERT, 32'hFFFF_FFFF);
      issue(FUNC_INSERT, 32'hA5A5_A5A5);
      issue(FUNC_INSERT, 32'h5A5A_5A5A);
      issue(FUNC_INSERT, 32'hFFFF_FFFF);

      // Hits and misses; remove takes only the frontmost duplicate.
      issue(FUNC_FIND,   32'hFFFF_FFFF);
      issue(FUNC_FIND,   32'h1234_5678);
      issue(FUNC_USE,    32'h0000_0000);
      issue(FUNC_REMOVE, 32'hFFFF_FFFF);
      issue(FUNC_REMOVE, 32'h1234_5678);
      issue(FUNC_USE,    32'h1234_5678);

      // Capacity dropped below the count: insert evicts one rear entry and leaves
      // the count where it was; a use hit lowers the count by one.
      write_capacity(5'd2);
      issue(FUNC_INSERT, 32'h0000_0001);
      issue(FUNC_USE,    32'hA5A5_A5A5);

      // Zero capacity behaves as one.
      write_capacity(5'd0);
      issue(FUNC_INSERT, 32'h0000_0002);
      issue(FUNC_FIND,   32'h0000_0002);

      // Over-range capacity behaves as the full row.
      write_capacity(5'd31);
      issue(FUNC_INSERT, 32'h0000_0003);
      issue(FUNC_INSERT, 32'h0000_0004);

      // Random phases: cycle through the four idle mixes, change capacity
      // between phases without clearing the table.
      for (int p = 0; p < 8; p++) begin
         write_capacity(phase_cap[p]);
         mode = p % 4;
         case (mode)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 56; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 56; end
            default: begin send_idle_pct = 25; rsp_stall_pct = 25; end
         endcase
         foreach (key_pool[j]) key_pool[j] = $urandom;
         for (int i = 0; i < 205; i++) begin
            // Pause the sender mid-phase until the table drains.
            if (i == 102) settle();
            issue(pick_func(), pick_key());
         end
      end

      req_valid = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      while (table_chk.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("Covered %0d requests, %0d with flag set, over %0d capacity writes",
               table_chk.requests, table_chk.flagged, cap_writes);
      $display("Idle mixes: none, sender only, receiver only, both");
      if (table_chk.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
